FILE: rtl/pspc_pkg.sv
// ----------------------------------------------------------------------------
// pspc_pkg
// Shared widths, constants, codes and control structures of the PID servo
// pulse controller.
// ----------------------------------------------------------------------------
package pspc_pkg;

  localparam int DUTY_BITS    = 16;
  localparam int FRAME_US     = 20000;
  localparam int PULSE_MIN_US = 1000;
  localparam int PULSE_MAX_US = 1500;
  localparam int DUTY_MAX     = (1 << DUTY_BITS) - 1;

  localparam int MS_SCALE = 1000;
  localparam int US_SCALE = 1000000;

  localparam int ANGLE_W = 17;
  localparam int ERR_W   = 18;
  localparam int DIFF_W  = 19;
  localparam int SUM_W   = 24;
  localparam int GAIN_W  = 16;
  localparam int STEP_W  = 10;
  localparam int BIAS_W  = 11;
  localparam int LIMIT_W = 23;
  localparam int PULSE_W = 11;
  localparam int DUTY_W  = DUTY_BITS;

  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_A_W = 41;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = 62;
  localparam int SCALE_W = 20;

  localparam int FRAC_BITS      = 16;
  localparam int DIV_W          = 44;
  localparam int DIVISOR_W      = 20;
  localparam int REM_W          = DIVISOR_W;
  localparam int CTRL_DIV_STEPS = DIV_W / 2;
  localparam int CNT_W          = 5;

  // The duty word is pulse * DUTY_MAX / FRAME_US, formed as one product with
  // a rounded-up reciprocal; it is exact for every pulse width below 2048.
  localparam int     DUTY_SHIFT = 26;
  localparam longint DUTY_RECIP = ((longint'(DUTY_MAX) << DUTY_SHIFT) + FRAME_US - 1)
                                  / FRAME_US;

  localparam int CTRL_SAT_W   = 12;
  localparam int CTRL_SAT_MAX = (1 << CTRL_SAT_W) - 1;
  localparam int PULSE_S_W    = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT,
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_STEP_MS,
    CFG_BIAS_US,
    CFG_SUM_LIMIT
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_DT_MS,
    MUL_DT_DT,
    MUL_ERR_KP,
    MUL_BY_K1,
    MUL_SUM_KI,
    MUL_BY_K2,
    MUL_DIFF_KD,
    MUL_BY_US,
    MUL_DUTY
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    DIV_HOLD,
    DIV_LOAD_CTRL,
    DIV_STEP
  } div_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DT_MS,
    S_DT_SQ,
    S_P_GAIN,
    S_P_SCALE,
    S_I_GAIN,
    S_I_SCALE,
    S_D_GAIN,
    S_D_SCALE,
    S_SUM,
    S_CDIV_LD,
    S_CDIV,
    S_PULSE,
    S_DUTY_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    prep;
    mul_op_t mul_op;
    logic    k1_ld;
    logic    k2_ld;
    acc_op_t acc_op;
    div_op_t div_op;
    logic    state_upd;
    logic    pulse_ld;
    logic    out_ld;
  } pspc_cmd_t;

  typedef struct packed {
    logic div_last;
  } pspc_sts_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] setpoint;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [STEP_W-1:0]  step_ms;
    logic [BIAS_W-1:0]  bias_us;
    logic [LIMIT_W-1:0] sum_limit;
  } pspc_cfg_t;

endpackage

FILE: rtl/pspc_if.sv
// ----------------------------------------------------------------------------
// pspc_if
// Valid/ready channels of the PID servo pulse controller: angle samples in,
// pulse results out.
// ----------------------------------------------------------------------------
interface pspc_in_if import pspc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface pspc_out_if import pspc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [PULSE_W-1:0]      pulse_us;
  logic [DUTY_W-1:0]       duty;
  logic                    pulse_clamped;
  logic signed [ERR_W-1:0] error_out;

  modport source (output valid, output pulse_us, output duty, output pulse_clamped,
                  output error_out, input ready);
  modport sink (input valid, input pulse_us, input duty, input pulse_clamped,
                input error_out, output ready);
endinterface

FILE: rtl/pid_servo_pulse_controller.sv
// ----------------------------------------------------------------------------
// pid_servo_pulse_controller
// PID servo loop with integral clamp that turns angle samples into a
// clamped drive pulse width and its duty word.
//
// The in_ch channel takes one signed Q.8 angle sample per transfer; out_ch
// returns one result per sample: pulse width, duty, clamp flag and error.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while the block is idle, which the block does not
// enforce itself. A write is registered and unknown indexes are ignored.
// A sample is accepted only when the sequencer is idle, so a new sample is
// taken only after the result of the last one has reached the output
// register. The time per sample is set by the shared multiplier (nine
// products, one per cycle) and the two-bit-per-cycle divider, which forms
// the control value; the duty word is a single reciprocal product.
// The result sits in an output register, so the next sample is accepted
// while it waits. If the receiver stalls with a result still pending, the
// next one holds in the sequencer until the register frees up.
// Reset (synchronous, rst_n low) restores the default configuration,
// clears the prior error and the error sum, and drops out_ch.valid.
// ----------------------------------------------------------------------------
module pid_servo_pulse_controller import pspc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pspc_in_if.sink              in_ch,
  pspc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  pspc_cfg_t cfg;
  pspc_cmd_t cmd;
  pspc_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  pspc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pspc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pspc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .angle         (in_ch.angle),
    .sts           (sts),
    .pulse_us      (out_ch.pulse_us),
    .duty          (out_ch.duty),
    .pulse_clamped (out_ch.pulse_clamped),
    .error_out     (out_ch.error_out)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

FILE: rtl/pspc_regs.sv
// ----------------------------------------------------------------------------
// pspc_regs
// Configuration register file: setpoint, gains, loop interval, bias and
// error sum limit, written through a plain write port.
// ----------------------------------------------------------------------------
module pspc_regs import pspc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output pspc_cfg_t            cfg
);

  pspc_cfg_t cfg_r;
  pspc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SETPOINT:  cfg_nxt.setpoint  = cfg_wdata[ANGLE_W-1:0];
        CFG_GAIN_P:    cfg_nxt.gain_p    = cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_I:    cfg_nxt.gain_i    = cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_D:    cfg_nxt.gain_d    = cfg_wdata[GAIN_W-1:0];
        CFG_STEP_MS:   cfg_nxt.step_ms   = cfg_wdata[STEP_W-1:0];
        CFG_BIAS_US:   cfg_nxt.bias_us   = cfg_wdata[BIAS_W-1:0];
        CFG_SUM_LIMIT: cfg_nxt.sum_limit = cfg_wdata[LIMIT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint  <= ANGLE_W'(11520);
      cfg_r.gain_p    <= GAIN_W'(128);
      cfg_r.gain_i    <= GAIN_W'(512);
      cfg_r.gain_d    <= GAIN_W'(64);
      cfg_r.step_ms   <= STEP_W'(50);
      cfg_r.bias_us   <= BIAS_W'(1300);
      cfg_r.sum_limit <= LIMIT_W'(128000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/pspc_dp.sv
// ----------------------------------------------------------------------------
// pspc_dp
// Datapath: error and saturating sum, one shared signed multiplier, the
// control numerator accumulator, a two-bit-per-cycle restoring divider,
// pulse clamp and the result register.
// ----------------------------------------------------------------------------
module pspc_dp import pspc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pspc_cfg_t                 cfg,
  input  pspc_cmd_t                 cmd,
  input  logic signed [ANGLE_W-1:0] angle,
  output pspc_sts_t                 sts,
  output logic [PULSE_W-1:0]        pulse_us,
  output logic [DUTY_W-1:0]         duty,
  output logic                      pulse_clamped,
  output logic signed [ERR_W-1:0]   error_out
);

  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic [STEP_W-1:0]        dt_r, dt_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [SUM_W-1:0]  esum_r, esum_nxt;
  logic signed [ERR_W-1:0]  prior_r, prior_nxt;
  logic [SCALE_W-1:0]       k1_r, k1_nxt;
  logic [SCALE_W-1:0]       k2_r, k2_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic [DIV_W-1:0]         dq_r, dq_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]     dvs_r, dvs_nxt;
  logic                     neg_r, neg_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [PULSE_W-1:0]       pulse_r, pulse_nxt;
  logic                     clamped_r, clamped_nxt;
  logic [PULSE_W-1:0]       out_pulse_r, out_pulse_nxt;
  logic [DUTY_W-1:0]        out_duty_r, out_duty_nxt;
  logic                     out_clamped_r, out_clamped_nxt;
  logic signed [ERR_W-1:0]  out_err_r, out_err_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [SUM_W:0]     sum_raw;
  logic signed [SUM_W:0]     lim_s;
  logic [PROD_W-1:0]         acc_mag;
  logic [CTRL_SAT_W-1:0]     ctrl_sat;
  logic signed [PULSE_S_W-1:0] ctrl_s;
  logic signed [PULSE_S_W-1:0] pulse_s;
  logic [PROD_W-DUTY_SHIFT-1:0] duty_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_DT_MS: begin
        mul_a = MUL_A_W'(dt_r);
        mul_b = MUL_B_W'(MS_SCALE);
      end
      MUL_DT_DT: begin
        mul_a = MUL_A_W'(dt_r);
        mul_b = MUL_B_W'(dt_r);
      end
      MUL_ERR_KP: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = MUL_B_W'(cfg.gain_p);
      end
      MUL_BY_K1: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(k1_r);
      end
      MUL_SUM_KI: begin
        mul_a = MUL_A_W'(sum_r);
        mul_b = MUL_B_W'(cfg.gain_i);
      end
      MUL_BY_K2: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(k2_r);
      end
      MUL_DIFF_KD: begin
        mul_a = MUL_A_W'(diff_r);
        mul_b = MUL_B_W'(cfg.gain_d);
      end
      MUL_BY_US: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(US_SCALE);
      end
      MUL_DUTY: begin
        mul_a = MUL_A_W'(DUTY_RECIP);
        mul_b = MUL_B_W'(pulse_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sum_raw  = (SUM_W+1)'(esum_r) + (SUM_W+1)'(err_r);
  assign lim_s    = $signed({2'b00, cfg.sum_limit});
  assign acc_mag  = acc_r[PROD_W-1] ? PROD_W'(-acc_r) : PROD_W'(acc_r);
  assign ctrl_sat = (dq_r > DIV_W'(CTRL_SAT_MAX)) ? CTRL_SAT_W'(CTRL_SAT_MAX)
                                                  : dq_r[CTRL_SAT_W-1:0];
  assign ctrl_s   = neg_r ? -$signed({2'b00, ctrl_sat}) : $signed({2'b00, ctrl_sat});
  assign pulse_s  = ctrl_s + $signed({3'b000, cfg.bias_us});
  assign duty_q   = prod_r[PROD_W-1:DUTY_SHIFT];

  always_comb begin
    logic [REM_W:0]   t;
    logic [REM_W-1:0] r;
    logic [DIV_W-1:0] q;

    err_nxt         = err_r;
    dt_nxt          = dt_r;
    sum_nxt         = sum_r;
    diff_nxt        = diff_r;
    esum_nxt        = esum_r;
    prior_nxt       = prior_r;
    k1_nxt          = k1_r;
    k2_nxt          = k2_r;
    prod_nxt        = prod_r;
    acc_nxt         = acc_r;
    dq_nxt          = dq_r;
    rem_nxt         = rem_r;
    dvs_nxt         = dvs_r;
    neg_nxt         = neg_r;
    cnt_nxt         = cnt_r;
    pulse_nxt       = pulse_r;
    clamped_nxt     = clamped_r;
    out_pulse_nxt   = out_pulse_r;
    out_duty_nxt    = out_duty_r;
    out_clamped_nxt = out_clamped_r;
    out_err_nxt     = out_err_r;
    t               = '0;
    r               = rem_r;
    q               = dq_r;

    if (cmd.capture) begin
      err_nxt = ERR_W'(angle) - ERR_W'($signed(cfg.setpoint));
      dt_nxt  = (cfg.step_ms == '0) ? STEP_W'(1) : cfg.step_ms;
    end

    if (cmd.prep) begin
      if (sum_raw > lim_s) begin
        sum_nxt = SUM_W'(lim_s);
      end else if (sum_raw < -lim_s) begin
        sum_nxt = SUM_W'(-lim_s);
      end else begin
        sum_nxt = SUM_W'(sum_raw);
      end
      diff_nxt = DIFF_W'(err_r) - DIFF_W'(prior_r);
    end

    if (cmd.mul_op != MUL_NONE) begin
      prod_nxt = mul_a * $signed({1'b0, mul_b});
    end
    if (cmd.k1_ld) begin
      k1_nxt = prod_r[SCALE_W-1:0];
    end
    if (cmd.k2_ld) begin
      k2_nxt = prod_r[SCALE_W-1:0];
    end

    case (cmd.acc_op)
      ACC_LOAD: acc_nxt = prod_r;
      ACC_ADD:  acc_nxt = acc_r + prod_r;
      default:  acc_nxt = acc_r;
    endcase

    if (cmd.state_upd) begin
      esum_nxt  = sum_r;
      prior_nxt = err_r;
    end

    case (cmd.div_op)
      DIV_LOAD_CTRL: begin
        neg_nxt = acc_r[PROD_W-1];
        dq_nxt  = acc_mag[FRAC_BITS +: DIV_W];
        rem_nxt = '0;
        dvs_nxt = k1_r;
        cnt_nxt = CNT_W'(CTRL_DIV_STEPS - 1);
      end
      DIV_STEP: begin
        for (int i = 0; i < 2; i++) begin
          t = {r, q[DIV_W-1]};
          q = {q[DIV_W-2:0], 1'b0};
          if (t >= {1'b0, dvs_r}) begin
            t    = t - {1'b0, dvs_r};
            q[0] = 1'b1;
          end
          r = t[REM_W-1:0];
        end
        dq_nxt  = q;
        rem_nxt = r;
        cnt_nxt = cnt_r - 1'b1;
      end
      default: begin
        dq_nxt = dq_r;
      end
    endcase

    if (cmd.pulse_ld) begin
      if (pulse_s < PULSE_S_W'(PULSE_MIN_US)) begin
        pulse_nxt   = PULSE_W'(PULSE_MIN_US);
        clamped_nxt = 1'b1;
      end else if (pulse_s > PULSE_S_W'(PULSE_MAX_US)) begin
        pulse_nxt   = PULSE_W'(PULSE_MAX_US);
        clamped_nxt = 1'b1;
      end else begin
        pulse_nxt   = pulse_s[PULSE_W-1:0];
        clamped_nxt = 1'b0;
      end
    end

    if (cmd.out_ld) begin
      out_pulse_nxt   = pulse_r;
      out_duty_nxt    = (duty_q > (PROD_W-DUTY_SHIFT)'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                                  : duty_q[DUTY_W-1:0];
      out_clamped_nxt = clamped_r;
      out_err_nxt     = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esum_r  <= '0;
      prior_r <= '0;
      cnt_r   <= '0;
    end else begin
      esum_r  <= esum_nxt;
      prior_r <= prior_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r         <= err_nxt;
    dt_r          <= dt_nxt;
    sum_r         <= sum_nxt;
    diff_r        <= diff_nxt;
    k1_r          <= k1_nxt;
    k2_r          <= k2_nxt;
    prod_r        <= prod_nxt;
    acc_r         <= acc_nxt;
    dq_r          <= dq_nxt;
    rem_r         <= rem_nxt;
    dvs_r         <= dvs_nxt;
    neg_r         <= neg_nxt;
    pulse_r       <= pulse_nxt;
    clamped_r     <= clamped_nxt;
    out_pulse_r   <= out_pulse_nxt;
    out_duty_r    <= out_duty_nxt;
    out_clamped_r <= out_clamped_nxt;
    out_err_r     <= out_err_nxt;
  end

  assign sts.div_last  = (cnt_r == '0);
  assign pulse_us      = out_pulse_r;
  assign duty          = out_duty_r;
  assign pulse_clamped = out_clamped_r;
  assign error_out     = out_err_r;

endmodule

FILE: rtl/pspc_ctrl.sv
// ----------------------------------------------------------------------------
// pspc_ctrl
// Sequencer of the PID servo pulse controller: steps the datapath through
// the products, the division and the clamp, and owns the result valid.
// ----------------------------------------------------------------------------
module pspc_ctrl import pspc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  input  pspc_sts_t sts,
  output logic      in_ready,
  output logic      out_valid,
  output pspc_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DT_MS;
      S_DT_MS:    state_nxt = S_DT_SQ;
      S_DT_SQ:    state_nxt = S_P_GAIN;
      S_P_GAIN:   state_nxt = S_P_SCALE;
      S_P_SCALE:  state_nxt = S_I_GAIN;
      S_I_GAIN:   state_nxt = S_I_SCALE;
      S_I_SCALE:  state_nxt = S_D_GAIN;
      S_D_GAIN:   state_nxt = S_D_SCALE;
      S_D_SCALE:  state_nxt = S_SUM;
      S_SUM:      state_nxt = S_CDIV_LD;
      S_CDIV_LD:  state_nxt = S_CDIV;
      S_CDIV:     if (sts.div_last) state_nxt = S_PULSE;
      S_PULSE:    state_nxt = S_DUTY_MUL;
      S_DUTY_MUL: state_nxt = S_DONE;
      S_DONE:     if (slot_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE:    cmd.capture = in_valid;
      S_DT_MS: begin
        cmd.prep   = 1'b1;
        cmd.mul_op = MUL_DT_MS;
      end
      S_DT_SQ: begin
        cmd.k1_ld  = 1'b1;
        cmd.mul_op = MUL_DT_DT;
      end
      S_P_GAIN: begin
        cmd.k2_ld  = 1'b1;
        cmd.mul_op = MUL_ERR_KP;
      end
      S_P_SCALE: cmd.mul_op = MUL_BY_K1;
      S_I_GAIN: begin
        cmd.acc_op = ACC_LOAD;
        cmd.mul_op = MUL_SUM_KI;
      end
      S_I_SCALE: cmd.mul_op = MUL_BY_K2;
      S_D_GAIN: begin
        cmd.acc_op = ACC_ADD;
        cmd.mul_op = MUL_DIFF_KD;
      end
      S_D_SCALE: cmd.mul_op = MUL_BY_US;
      S_SUM:     cmd.acc_op = ACC_ADD;
      S_CDIV_LD: begin
        cmd.div_op    = DIV_LOAD_CTRL;
        cmd.state_upd = 1'b1;
      end
      S_CDIV:     cmd.div_op = DIV_STEP;
      S_PULSE:    cmd.pulse_ld = 1'b1;
      S_DUTY_MUL: cmd.mul_op = MUL_DUTY;
      S_DONE:     cmd.out_ld = slot_free;
      default:    cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DT_MS))
    else $error("Accepted sample did not start the sequence.");

  a_ctrl_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CDIV_LD) |=> ##CTRL_DIV_STEPS (state_r == S_PULSE))
    else $error("Control division ran for the wrong number of cycles.");

  a_duty_one_product: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUTY_MUL) |=> (state_r == S_DONE))
    else $error("Duty product did not complete in one cycle.");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE && out_valid_r))
    else $error("Result overwrote a transfer that was still pending.");

endmodule

FILE: sim/pid_servo_pulse_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_servo_pulse_controller_tb
// Self-checking bench for the PID servo pulse controller. A directed run
// covers field extremes, exact pulse bounds, clamping, negative pulses, a
// zero interval and an unknown register index. It is followed by random
// phases that each load a fresh configuration, one with all fields but the
// setpoint at their largest and one with the smallest interval and sum
// limit. An in-bench mirror of the loop predicts each pulse, duty, clamp
// flag and error, and checks them in order against the output channel. Both
// channels idle at random, except in one steady phase. In one phase the
// receiver holds off for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module pid_servo_pulse_controller_tb;
  import pspc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 160;
  localparam int RANDOM_PHASES = 8;
  localparam int HOLD_CYCLES = 600;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(CFG_SUM_LIMIT) + 1'b1;

  typedef struct packed {
    logic [PULSE_W-1:0]      pulse_us;
    logic [DUTY_W-1:0]       duty;
    logic                    pulse_clamped;
    logic signed [ERR_W-1:0] error_out;
  } pulse_res_t;

  class servo_loop_mirror;
    logic signed [ANGLE_W-1:0] setpoint;
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_d;
    logic [STEP_W-1:0]         step_ms;
    logic [BIAS_W-1:0]         bias_us;
    logic [LIMIT_W-1:0]        sum_limit;
    longint                    prior_err;
    longint                    err_sum;
    pulse_res_t                pending_pulses[$];
    int                        pulse_errors;

    function new();
      setpoint    = 11520;
      gain_p      = 128;
      gain_i      = 512;
      gain_d      = 64;
      step_ms     = 50;
      bias_us     = 1300;
      sum_limit   = 128000;
      prior_err   = 0;
      err_sum     = 0;
      pulse_errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_SETPOINT:  setpoint  = data[ANGLE_W-1:0];
        CFG_GAIN_P:    gain_p    = data[GAIN_W-1:0];
        CFG_GAIN_I:    gain_i    = data[GAIN_W-1:0];
        CFG_GAIN_D:    gain_d    = data[GAIN_W-1:0];
        CFG_STEP_MS:   step_ms   = data[STEP_W-1:0];
        CFG_BIAS_US:   bias_us   = data[BIAS_W-1:0];
        CFG_SUM_LIMIT: sum_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_angle(logic signed [ANGLE_W-1:0] angle);
      longint err, sum, lim, dt, num, den, ctrl, pulse;
      pulse_res_t res;
      err = longint'(angle) - longint'(setpoint);
      lim = longint'(sum_limit);
      dt  = (step_ms == '0) ? 1 : longint'(step_ms);
      sum = err_sum + err;
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      num = longint'(gain_p) * err * MS_SCALE * dt
          + longint'(gain_i) * sum * dt * dt
          + longint'(gain_d) * (err - prior_err) * US_SCALE;
      den = (longint'(1) << FRAC_BITS) * MS_SCALE * dt;
      ctrl = num / den;
      pulse = ctrl + longint'(bias_us);
      res.pulse_clamped = 1'b0;
      if (pulse < PULSE_MIN_US) begin
        pulse = PULSE_MIN_US;
        res.pulse_clamped = 1'b1;
      end
      if (pulse > PULSE_MAX_US) begin
        pulse = PULSE_MAX_US;
        res.pulse_clamped = 1'b1;
      end
      res.pulse_us  = PULSE_W'(pulse);
      res.duty      = DUTY_W'(pulse * DUTY_MAX / FRAME_US);
      res.error_out = ERR_W'(err);
      err_sum   = sum;
      prior_err = err;
      pending_pulses.push_back(res);
    endfunction

    function void match_pulse(pulse_res_t got);
      pulse_res_t want;
      bit bad;
      if (pending_pulses.size() == 0) begin
        pulse_errors++;
        if (pulse_errors <= 10)
          $display("%0t: result with no sample pending: pulse %0d duty %0d clamp %0b err %0d",
                   $realtime, got.pulse_us, got.duty, got.pulse_clamped, got.error_out);
        return;
      end
      want = pending_pulses.pop_front();
      bad = (got.pulse_us !== want.pulse_us) || (got.duty !== want.duty)
         || (got.pulse_clamped !== want.pulse_clamped) || (got.error_out !== want.error_out);
      if (bad) begin
        pulse_errors++;
        if (pulse_errors <= 10)
          $display("%0t: mismatch: pulse %0d/%0d duty %0d/%0d clamp %0b/%0b err %0d/%0d (exp/act)",
                   $realtime, want.pulse_us, got.pulse_us, want.duty, got.duty,
                   want.pulse_clamped, got.pulse_clamped, want.error_out, got.error_out);
      end
    endfunction

    function int pending();
      return pending_pulses.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  bit steady;
  bit squeeze;
  int unsigned cycle_count;
  servo_loop_mirror mirror;

  pspc_in_if  in_ch();
  pspc_out_if out_ch();

  pid_servo_pulse_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    mirror.write_reg(idx, data);
  endtask

  task automatic close_cfg();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
    while (!steady && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.angle <= angle;
    do @(posedge clk); while (!in_ch.ready);
    mirror.take_angle(angle);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_list(input int angles[]);
    foreach (angles[i]) send_angle(ANGLE_W'(angles[i]));
    settle();
  endtask

  function automatic logic [CFG_W-1:0] with_noise(input logic [CFG_W-1:0] v, input int w);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    if ($urandom_range(3) == 0) return v | ((junk >> w) << w);
    return v;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(3))
      0: return '0;
      1: return GAIN_W'($urandom_range(1023));
      2: return GAIN_W'($urandom);
      default: return '1;
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(4))
      0: return STEP_W'($urandom_range(3));
      1: return '1;
      default: return STEP_W'($urandom_range(1000, 1));
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(4))
      0: return '0;
      1: return LIMIT_W'($urandom_range(4095));
      2: return '1;
      default: return LIMIT_W'($urandom_range(512000));
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int offset;
    if ($urandom_range(9) < 7) begin
      offset = $urandom_range(4096) - 2048;
      return ANGLE_W'(int'(mirror.setpoint) + offset);
    end
    return ANGLE_W'($urandom);
  endfunction

  task automatic random_phase(input int kind);
    logic [ANGLE_W-1:0] sp;
    sp = ($urandom_range(3) == 0) ? ANGLE_W'($urandom)
                                  : ANGLE_W'($urandom_range(92160) - 46080);
    write_reg(CFG_SETPOINT, with_noise(CFG_W'(sp), ANGLE_W));
    if (kind == 0) begin
      write_reg(CFG_GAIN_P, '1);
      write_reg(CFG_GAIN_I, '1);
      write_reg(CFG_GAIN_D, '1);
      write_reg(CFG_STEP_MS, '1);
      write_reg(CFG_BIAS_US, '1);
      write_reg(CFG_SUM_LIMIT, '1);
    end else if (kind == 1) begin
      write_reg(CFG_GAIN_P, CFG_W'(pick_gain()));
      write_reg(CFG_GAIN_I, CFG_W'(pick_gain()));
      write_reg(CFG_GAIN_D, CFG_W'(pick_gain()));
      write_reg(CFG_STEP_MS, CFG_W'(1));
      write_reg(CFG_BIAS_US, CFG_W'(PULSE_MIN_US));
      write_reg(CFG_SUM_LIMIT, '0);
    end else begin
      write_reg(CFG_GAIN_P, with_noise(CFG_W'(pick_gain()), GAIN_W));
      write_reg(CFG_GAIN_I, with_noise(CFG_W'(pick_gain()), GAIN_W));
      write_reg(CFG_GAIN_D, with_noise(CFG_W'(pick_gain()), GAIN_W));
      write_reg(CFG_STEP_MS, with_noise(CFG_W'(pick_step()), STEP_W));
      if ($urandom_range(4) == 0)
        write_reg(CFG_BIAS_US, with_noise(CFG_W'($urandom_range(2047)), BIAS_W));
      else
        write_reg(CFG_BIAS_US, CFG_W'($urandom_range(1550, 950)));
      write_reg(CFG_SUM_LIMIT, CFG_W'(pick_limit()));
    end
    close_cfg();
    squeeze = (kind == 3);
    steady  = (kind == 4);
    repeat (PHASE_ITEMS) send_angle(pick_angle());
    settle();
    steady = 1'b0;
  endtask

  initial begin : drain
    int hold_left;
    bit squeezed;
    pulse_res_t got;
    hold_left = 0;
    squeezed  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.pulse_us, out_ch.duty, out_ch.pulse_clamped, out_ch.error_out};
        mirror.match_pulse(got);
      end
      if (squeeze && !squeezed) begin
        hold_left = HOLD_CYCLES;
        squeezed  = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  initial begin
    mirror = new();
    steady  = 1'b0;
    squeeze = 1'b0;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.angle <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_list('{11520, 0, -46080, 46080, 11521, 11519, -65536, 65535});

    write_reg(CFG_SETPOINT, '0);
    write_reg(CFG_GAIN_P, '0);
    write_reg(CFG_GAIN_I, '0);
    write_reg(CFG_GAIN_D, '0);
    write_reg(CFG_STEP_MS, '0);
    write_reg(CFG_SUM_LIMIT, '0);
    write_reg(CFG_BIAS_US, CFG_W'(PULSE_MIN_US));
    close_cfg();
    send_list('{0, 65535});
    write_reg(CFG_BIAS_US, CFG_W'(PULSE_MAX_US));
    close_cfg();
    send_list('{-65536, 0});
    write_reg(CFG_BIAS_US, CFG_W'(PULSE_MIN_US - 1));
    close_cfg();
    send_list('{0});
    write_reg(CFG_BIAS_US, CFG_W'(PULSE_MAX_US + 1));
    close_cfg();
    send_list('{0});

    // A large negative control value must clamp to the lower bound.
    write_reg(CFG_BIAS_US, '0);
    write_reg(CFG_GAIN_P, '1);
    write_reg(CFG_GAIN_D, '1);
    close_cfg();
    send_list('{-65536, 65535, -65536});

    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_GAIN_I, '1);
    write_reg(CFG_STEP_MS, CFG_W'(1000));
    write_reg(CFG_SUM_LIMIT, '1);
    write_reg(CFG_BIAS_US, CFG_W'(1300));
    close_cfg();
    send_list('{65535, 65535, 65535, -65536});

    for (int k = 0; k < RANDOM_PHASES; k++) random_phase(k);

    if (mirror.pulse_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
